>>> rtl/bmst_pkg.sv
// shared constants, types and state codes for the spanning tree block
`timescale 1ns / 1ps
package bmst_pkg;

  localparam int MAX_VERTICES    = 32;
  localparam int VERT_BITS       = 5;
  localparam int VCOUNT_BITS     = 6;
  localparam int WEIGHT_BITS     = 16;
  localparam int TOTAL_BITS      = 21;
  localparam int RANK_BITS       = 3;
  localparam int DEF_MAX_EDGES   = 256;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_SUM  = 1'b1;

  typedef struct packed {
    logic [VERT_BITS-1:0]   src;
    logic [VERT_BITS-1:0]   dst;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_t;

  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_INIT  = 17'h00002,
    ST_ROUND = 17'h00004,
    ST_SRD   = 17'h00008,
    ST_SLD   = 17'h00010,
    ST_SFA   = 17'h00020,
    ST_SFB   = 17'h00040,
    ST_SCA   = 17'h00080,
    ST_SCB   = 17'h00100,
    ST_MNEXT = 17'h00200,
    ST_MLD   = 17'h00400,
    ST_MFA   = 17'h00800,
    ST_MFB   = 17'h01000,
    ST_MRK   = 17'h02000,
    ST_MJOIN = 17'h04000,
    ST_EMIT  = 17'h08000,
    ST_SUM   = 17'h10000
  } state_t;

endpackage

>>> rtl/bmst_edge_mem.sv
// edge store: one write port, one registered read port
`timescale 1ns / 1ps
module bmst_edge_mem #(
  parameter int DEPTH     = bmst_pkg::DEF_MAX_EDGES,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  bmst_pkg::edge_t      wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output bmst_pkg::edge_t      rd_data
);
  import bmst_pkg::*;

  edge_t mem_r [DEPTH];
  edge_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/boruvka_minimum_spanning_tree.sv
// top level: edge loading, boruvka solve sequencer and result register
`timescale 1ns / 1ps
// Minimum spanning tree engine. Add-edge requests (command 0) are taken one
// per cycle while the block is idle and stored in load order; an edge with an
// endpoint at or above the vertex count is ignored, and one past MAX_EDGES is
// dropped and flagged. A solve request (command 1) runs Boruvka rounds over a
// union-find with union by rank and emits one result per tree edge, then a
// summary result (last = 1) with the total weight, a disconnected flag and
// the overflow flag; the edge store is then empty. One find walk on the
// parent table and one edge store read port are shared by every step. The
// block takes no request while it solves, and each result waits in a single
// output register until the receiver takes it.
module boruvka_minimum_spanning_tree #(
  parameter int MAX_EDGES = bmst_pkg::DEF_MAX_EDGES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_command,
  input  logic [bmst_pkg::VERT_BITS-1:0]   in_src_vertex,
  input  logic [bmst_pkg::VERT_BITS-1:0]   in_dst_vertex,
  input  logic [bmst_pkg::WEIGHT_BITS-1:0] in_edge_weight,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_kind,
  output logic [bmst_pkg::VERT_BITS-1:0]   out_src,
  output logic [bmst_pkg::VERT_BITS-1:0]   out_dst,
  output logic [bmst_pkg::WEIGHT_BITS-1:0] out_weight,
  output logic [bmst_pkg::TOTAL_BITS-1:0]  out_total_weight,
  output logic                             out_disconnected,
  output logic                             out_overflowed,
  output logic                             out_last,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bmst_pkg::VCOUNT_BITS-1:0] cfg_vertex_count
);
  import bmst_pkg::*;

  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam logic [CW-1:0] EDGE_CAP = CW'(MAX_EDGES);
  localparam logic [VCOUNT_BITS-1:0] NV_MAX = VCOUNT_BITS'(MAX_VERTICES);

  state_t state_r;

  logic [VCOUNT_BITS-1:0] vcount_r;
  logic [CW-1:0]          edge_count_r;
  logic                   ovf_r;
  logic [CW-1:0]          e_r;
  logic [VCOUNT_BITS-1:0] v_r;
  logic [VCOUNT_BITS-1:0] comp_r;
  logic [TOTAL_BITS-1:0]  total_r;
  logic                   disc_r;
  logic                   found_r;
  logic [VERT_BITS-1:0]   cur_r;
  logic [VERT_BITS-1:0]   a_r;
  logic [VERT_BITS-1:0]   b_r;
  logic [RANK_BITS-1:0]   ra_r;

  // union-find and per-component cheapest edge
  logic [VERT_BITS-1:0]   parent_r [MAX_VERTICES];
  logic [RANK_BITS-1:0]   rank_r   [MAX_VERTICES];
  logic [AW-1:0]          cidx_r   [MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] cw_r     [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] cv_r;

  // result register
  logic                   out_valid_r;
  logic                   out_kind_r;
  logic [VERT_BITS-1:0]   out_src_r;
  logic [VERT_BITS-1:0]   out_dst_r;
  logic [WEIGHT_BITS-1:0] out_weight_r;
  logic [TOTAL_BITS-1:0]  out_total_r;
  logic                   out_disc_r;
  logic                   out_ovf_r;
  logic                   out_last_r;

  logic [VCOUNT_BITS-1:0] nv;
  logic                   in_fire;
  logic                   in_in_range;
  logic                   wr_en;
  edge_t                  wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  edge_t                  rd_q;
  logic [VERT_BITS-1:0]   par_cur;
  logic                   out_free;
  logic                   rd_in_range;
  logic [TOTAL_BITS:0]    sum_ext;
  logic [TOTAL_BITS-1:0]  total_sat;
  logic [RANK_BITS-1:0]   rb;

  // active vertex count, zero taken as one and clipped at the table size
  always_comb begin
    if (vcount_r == '0) begin
      nv = VCOUNT_BITS'(1);
    end else if (vcount_r > NV_MAX) begin
      nv = NV_MAX;
    end else begin
      nv = vcount_r;
    end
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign in_fire     = in_valid && !in_stall;
  assign in_in_range = ({1'b0, in_src_vertex} < nv) && ({1'b0, in_dst_vertex} < nv);
  assign wr_en       = in_fire && (in_command == CMD_ADD) && in_in_range &&
                       (edge_count_r != EDGE_CAP);
  assign wr_data     = '{src: in_src_vertex, dst: in_dst_vertex, weight: in_edge_weight};

  assign cfg_ready = 1'b1;

  // one edge store read a step: the scan in SRD, the merge lookup in MNEXT
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = e_r[AW-1:0];
    if (state_r == ST_SRD && e_r != edge_count_r) begin
      rd_en = 1'b1;
    end else if (state_r == ST_MNEXT && v_r != nv && cv_r[v_r[VERT_BITS-1:0]]) begin
      rd_en   = 1'b1;
      rd_addr = cidx_r[v_r[VERT_BITS-1:0]];
    end
  end

  bmst_edge_mem #(
    .DEPTH     (MAX_EDGES),
    .ADDR_BITS (AW)
  ) u_edge_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (edge_count_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  assign par_cur     = parent_r[cur_r];
  assign out_free    = !out_valid_r || !out_stall;
  assign rd_in_range = ({1'b0, rd_q.src} < nv) && ({1'b0, rd_q.dst} < nv);
  assign sum_ext     = {1'b0, total_r} + (TOTAL_BITS + 1)'(rd_q.weight);
  assign total_sat   = (sum_ext > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum_ext[TOTAL_BITS-1:0];
  assign rb          = rank_r[b_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      vcount_r     <= NV_MAX;
      edge_count_r <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      cv_r         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_vertex_count;
      end
      // the emit states reload the result register themselves
      if (out_valid_r && !out_stall && !(state_r inside {ST_EMIT, ST_SUM})) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_command == CMD_SOLVE) begin
              state_r <= ST_INIT;
            end else if (in_in_range) begin
              if (edge_count_r == EDGE_CAP) begin
                ovf_r <= 1'b1;
              end else begin
                edge_count_r <= edge_count_r + CW'(1);
              end
            end
          end
        end
        ST_INIT: begin
          for (int i = 0; i < MAX_VERTICES; i++) begin
            parent_r[i] <= VERT_BITS'(i);
            rank_r[i]   <= '0;
          end
          comp_r  <= nv;
          total_r <= '0;
          disc_r  <= 1'b0;
          state_r <= (nv > VCOUNT_BITS'(1)) ? ST_ROUND : ST_SUM;
        end
        ST_ROUND: begin
          cv_r    <= '0;
          e_r     <= '0;
          found_r <= 1'b0;
          state_r <= ST_SRD;
        end
        ST_SRD: begin
          if (e_r == edge_count_r) begin
            if (!found_r) begin
              disc_r  <= 1'b1;
              state_r <= ST_SUM;
            end else begin
              v_r     <= '0;
              state_r <= ST_MNEXT;
            end
          end else begin
            state_r <= ST_SLD;
          end
        end
        ST_SLD: begin
          // stored edges beyond a lowered vertex count are skipped
          if (!rd_in_range) begin
            e_r     <= e_r + CW'(1);
            state_r <= ST_SRD;
          end else begin
            cur_r   <= rd_q.src;
            state_r <= ST_SFA;
          end
        end
        ST_SFA: begin
          if (par_cur == cur_r) begin
            a_r     <= cur_r;
            cur_r   <= rd_q.dst;
            state_r <= ST_SFB;
          end else begin
            cur_r <= par_cur;
          end
        end
        ST_SFB: begin
          if (par_cur == cur_r) begin
            b_r     <= cur_r;
            state_r <= ST_SCA;
          end else begin
            cur_r <= par_cur;
          end
        end
        ST_SCA: begin
          if (a_r == b_r) begin
            e_r     <= e_r + CW'(1);
            state_r <= ST_SRD;
          end else begin
            // strict compare keeps the earlier loaded edge on a tie
            if (!cv_r[a_r] || cw_r[a_r] > rd_q.weight) begin
              cv_r[a_r]   <= 1'b1;
              cidx_r[a_r] <= e_r[AW-1:0];
              cw_r[a_r]   <= rd_q.weight;
            end
            state_r <= ST_SCB;
          end
        end
        ST_SCB: begin
          if (!cv_r[b_r] || cw_r[b_r] > rd_q.weight) begin
            cv_r[b_r]   <= 1'b1;
            cidx_r[b_r] <= e_r[AW-1:0];
            cw_r[b_r]   <= rd_q.weight;
          end
          found_r <= 1'b1;
          e_r     <= e_r + CW'(1);
          state_r <= ST_SRD;
        end
        ST_MNEXT: begin
          // components walked in index order
          if (v_r == nv) begin
            state_r <= (comp_r > VCOUNT_BITS'(1)) ? ST_ROUND : ST_SUM;
          end else begin
            v_r <= v_r + VCOUNT_BITS'(1);
            if (cv_r[v_r[VERT_BITS-1:0]]) begin
              state_r <= ST_MLD;
            end
          end
        end
        ST_MLD: begin
          cur_r   <= rd_q.src;
          state_r <= ST_MFA;
        end
        ST_MFA: begin
          if (par_cur == cur_r) begin
            a_r     <= cur_r;
            cur_r   <= rd_q.dst;
            state_r <= ST_MFB;
          end else begin
            cur_r <= par_cur;
          end
        end
        ST_MFB: begin
          if (par_cur == cur_r) begin
            b_r     <= cur_r;
            state_r <= ST_MRK;
          end else begin
            cur_r <= par_cur;
          end
        end
        ST_MRK: begin
          if (a_r == b_r) begin
            state_r <= ST_MNEXT;
          end else begin
            ra_r    <= rank_r[a_r];
            state_r <= ST_MJOIN;
          end
        end
        ST_MJOIN: begin
          // union by rank
          if (ra_r < rb) begin
            parent_r[a_r] <= b_r;
          end else if (ra_r > rb) begin
            parent_r[b_r] <= a_r;
          end else begin
            parent_r[b_r] <= a_r;
            rank_r[a_r]   <= ra_r + RANK_BITS'(1);
          end
          comp_r  <= comp_r - VCOUNT_BITS'(1);
          total_r <= total_sat;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_EDGE;
            out_src_r    <= rd_q.src;
            out_dst_r    <= rd_q.dst;
            out_weight_r <= rd_q.weight;
            out_total_r  <= total_r;
            out_disc_r   <= 1'b0;
            out_ovf_r    <= 1'b0;
            out_last_r   <= 1'b0;
            state_r      <= ST_MNEXT;
          end
        end
        ST_SUM: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_SUM;
            out_src_r    <= '0;
            out_dst_r    <= '0;
            out_weight_r <= '0;
            out_total_r  <= total_r;
            out_disc_r   <= disc_r;
            out_ovf_r    <= ovf_r;
            out_last_r   <= 1'b1;
            edge_count_r <= '0;
            ovf_r        <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_src          = out_src_r;
  assign out_dst          = out_dst_r;
  assign out_weight       = out_weight_r;
  assign out_total_weight = out_total_r;
  assign out_disconnected = out_disc_r;
  assign out_overflowed   = out_ovf_r;
  assign out_last         = out_last_r;

endmodule

>>> test/testbench.sv
// self-checking testbench for the boruvka spanning tree block
`timescale 1ns / 1ps
module testbench;
  import bmst_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_EDGES;
  localparam int IDLE_LIMIT  = 400000;
  localparam int DRAIN_WAIT  = 20;

  typedef struct packed {
    logic                   command;
    logic [VERT_BITS-1:0]   src;
    logic [VERT_BITS-1:0]   dst;
    logic [WEIGHT_BITS-1:0] weight;
  } request_t;

  typedef struct packed {
    logic                   kind;
    logic [VERT_BITS-1:0]   src;
    logic [VERT_BITS-1:0]   dst;
    logic [WEIGHT_BITS-1:0] weight;
    logic [TOTAL_BITS-1:0]  total;
    logic                   disconnected;
    logic                   overflowed;
    logic                   last;
  } tree_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = 1'b0;
  logic [VERT_BITS-1:0] in_src_vertex = '0;
  logic [VERT_BITS-1:0] in_dst_vertex = '0;
  logic [WEIGHT_BITS-1:0] in_edge_weight = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_kind;
  logic [VERT_BITS-1:0] out_src;
  logic [VERT_BITS-1:0] out_dst;
  logic [WEIGHT_BITS-1:0] out_weight;
  logic [TOTAL_BITS-1:0] out_total_weight;
  logic out_disconnected;
  logic out_overflowed;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [VCOUNT_BITS-1:0] cfg_vertex_count = '0;

  boruvka_minimum_spanning_tree i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_src_vertex(in_src_vertex), .in_dst_vertex(in_dst_vertex),
    .in_edge_weight(in_edge_weight),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_src(out_src), .out_dst(out_dst), .out_weight(out_weight),
    .out_total_weight(out_total_weight), .out_disconnected(out_disconnected),
    .out_overflowed(out_overflowed), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_vertex_count(cfg_vertex_count)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: a private copy of the edge store and the union-find
  // ---------------------------------------------------------------------------
  logic [VERT_BITS-1:0]   mst_src   [STORE_DEPTH];
  logic [VERT_BITS-1:0]   mst_dst   [STORE_DEPTH];
  logic [WEIGHT_BITS-1:0] mst_wt    [STORE_DEPTH];
  int unsigned            mst_edges;
  bit                     mst_dropped;
  logic [VCOUNT_BITS-1:0] mst_vcount;
  int unsigned            uf_parent [MAX_VERTICES];
  int unsigned            uf_rank   [MAX_VERTICES];

  tree_item_t expected_tree[$];
  request_t   pending_requests[$];
  int         fail_count;
  int         sender_idle_pct;
  int         receiver_idle_pct;
  bit         hold_sender;
  int         sent;

  // out-of-range register values clamp to 1..MAX_VERTICES
  function automatic int unsigned live_vertices();
    if (mst_vcount == 0) return 1;
    if (mst_vcount > MAX_VERTICES) return MAX_VERTICES;
    return mst_vcount;
  endfunction

  // find with path compression, walk bounded by MAX_VERTICES steps
  function automatic int unsigned find_root(int unsigned v);
    int unsigned r;
    int unsigned nxt;
    int unsigned guard;
    r = v;
    guard = 0;
    while (uf_parent[r] != r && guard < MAX_VERTICES) begin
      r = uf_parent[r];
      guard++;
    end
    while (uf_parent[v] != r && guard > 0) begin
      nxt = uf_parent[v];
      uf_parent[v] = r;
      v = nxt;
      guard--;
    end
    return r;
  endfunction

  // apply one accepted request, queueing every tree item it causes
  task automatic predict_tree(request_t req);
    int unsigned n;
    int unsigned comps;
    int unsigned a;
    int unsigned b;
    int unsigned c;
    int unsigned best     [MAX_VERTICES];
    bit          best_ok  [MAX_VERTICES];
    bit          found;
    bit          disc;
    int unsigned emitted;
    logic [TOTAL_BITS:0] total;
    tree_item_t item;
    n = live_vertices();
    if (req.command == CMD_ADD) begin
      // endpoints past the vertex count are ignored, a full store drops and flags
      if (req.src >= n || req.dst >= n) return;
      if (mst_edges >= STORE_DEPTH) begin
        mst_dropped = 1'b1;
        return;
      end
      mst_src[mst_edges] = req.src;
      mst_dst[mst_edges] = req.dst;
      mst_wt[mst_edges] = req.weight;
      mst_edges++;
      return;
    end
    for (int v = 0; v < MAX_VERTICES; v++) begin
      uf_parent[v] = v;
      uf_rank[v] = 0;
    end
    comps = n;
    total = '0;
    disc = 1'b0;
    emitted = 0;
    while (comps > 1) begin
      found = 1'b0;
      for (int v = 0; v < MAX_VERTICES; v++) best_ok[v] = 1'b0;
      // cheapest edge per component, first loaded wins a tie
      for (int e = 0; e < mst_edges; e++) begin
        if (mst_src[e] >= n || mst_dst[e] >= n) continue;
        a = find_root(mst_src[e]);
        b = find_root(mst_dst[e]);
        if (a == b) continue;
        if (!best_ok[a] || mst_wt[best[a]] > mst_wt[e]) begin
          best[a] = e;
          best_ok[a] = 1'b1;
        end
        if (!best_ok[b] || mst_wt[best[b]] > mst_wt[e]) begin
          best[b] = e;
          best_ok[b] = 1'b1;
        end
        found = 1'b1;
      end
      if (!found) begin
        disc = 1'b1;
        break;
      end
      // merge in component index order
      for (int v = 0; v < n; v++) begin
        if (!best_ok[v]) continue;
        c = best[v];
        a = find_root(mst_src[c]);
        b = find_root(mst_dst[c]);
        if (a == b) continue;
        if (uf_rank[a] < uf_rank[b]) uf_parent[a] = b;
        else if (uf_rank[a] > uf_rank[b]) uf_parent[b] = a;
        else begin
          uf_parent[b] = a;
          uf_rank[a]++;
        end
        comps--;
        total = total + mst_wt[c];
        if (total > TOTAL_MAX) total = TOTAL_MAX;
        if (emitted < 31) begin
          item = '{KIND_EDGE, mst_src[c], mst_dst[c], mst_wt[c],
                   total[TOTAL_BITS-1:0], 1'b0, 1'b0, 1'b0};
          expected_tree = {expected_tree, item};
          emitted++;
        end
      end
    end
    item = '{KIND_SUM, '0, '0, '0, total[TOTAL_BITS-1:0], disc, mst_dropped, 1'b1};
    expected_tree = {expected_tree, item};
    mst_edges = 0;
    mst_dropped = 1'b0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // request not taken at the last rising edge, read by the driver
  logic in_stall_seen = 1'b0;
  int   idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // driver: next queued request goes out at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall_seen) begin
        // request still waiting, payload stays put
      end else if (!hold_sender && pending_requests.size() > 0 &&
                   $urandom_range(99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        in_command <= pending_requests[0].command;
        in_src_vertex <= pending_requests[0].src;
        in_dst_vertex <= pending_requests[0].dst;
        in_edge_weight <= pending_requests[0].weight;
        void'(pending_requests.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: accepted requests feed the predictor, results are checked
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tree_item_t want;
    bit         moved;
    in_stall_seen <= !(in_valid && !in_stall);
    if (rst_n) begin
      moved = (in_valid && !in_stall) || (out_valid && !out_stall) ||
              (cfg_valid && cfg_ready);
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (in_valid && !in_stall) begin
        predict_tree('{in_command, in_src_vertex, in_dst_vertex, in_edge_weight});
      end
      if (out_valid && !out_stall) begin
        if (expected_tree.size() == 0) begin
          report_mismatch("unexpected result kind", out_kind, -1);
        end else begin
          want = expected_tree.pop_front();
          if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
          if (out_src !== want.src) report_mismatch("src", out_src, want.src);
          if (out_dst !== want.dst) report_mismatch("dst", out_dst, want.dst);
          if (out_weight !== want.weight) report_mismatch("weight", out_weight, want.weight);
          if (out_total_weight !== want.total)
            report_mismatch("total_weight", out_total_weight, want.total);
          if (out_disconnected !== want.disconnected)
            report_mismatch("disconnected", out_disconnected, want.disconnected);
          if (out_overflowed !== want.overflowed)
            report_mismatch("overflowed", out_overflowed, want.overflowed);
          if (out_last !== want.last) report_mismatch("last", out_last, want.last);
        end
      end
      // watchdog: nothing accepted for too long
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic request_t add_edge(int s, int d, int w);
    return '{CMD_ADD, s[VERT_BITS-1:0], d[VERT_BITS-1:0], w[WEIGHT_BITS-1:0]};
  endfunction

  function automatic request_t solve_req();
    request_t r;
    r = '{CMD_SOLVE, VERT_BITS'($urandom), VERT_BITS'($urandom), WEIGHT_BITS'($urandom)};
    return r;
  endfunction

  // append one request to the driver queue and count it
  task automatic queue_request(request_t r);
    pending_requests = {pending_requests, r};
    sent++;
  endtask

  // wait until every queued request is taken and all results are back
  task automatic drain();
    while (pending_requests.size() > 0 || in_valid || expected_tree.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // write the vertex count while the block is idle
  task automatic write_vertex_count(int value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_vertex_count <= value[VCOUNT_BITS-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mst_vcount = value[VCOUNT_BITS-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one random graph: mostly in-range edges, a little noise, then a solve
  task automatic queue_graph(int nv, int edges, int wmax);
    int s;
    int d;
    for (int i = 0; i < edges; i++) begin
      s = $urandom_range(nv - 1);
      d = $urandom_range(nv - 1);
      if ($urandom_range(19) == 0) s = $urandom_range(31);
      queue_request(add_edge(s, d, $urandom_range(wmax)));
    end
    queue_request(solve_req());
  endtask

  int nv;
  int random_base;

  initial begin
    mst_edges = 0;
    mst_dropped = 1'b0;
    mst_vcount = MAX_VERTICES;
    fail_count = 0;
    hold_sender = 1'b0;
    sent = 0;
    sender_idle_pct = 32;
    receiver_idle_pct = 57;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: a small ring with a weight tie, a self loop and out-of-range ends
    write_vertex_count(4);
    queue_request(add_edge(0, 1, 5));
    queue_request(add_edge(1, 2, 5));
    queue_request(add_edge(2, 3, 65535));
    queue_request(add_edge(3, 0, 0));
    queue_request(add_edge(2, 2, 1));
    queue_request(add_edge(31, 0, 7));
    queue_request(add_edge(0, 4, 7));
    queue_request(solve_req());
    // disconnected: vertex 3 never reached
    queue_request(add_edge(0, 1, 10));
    queue_request(add_edge(1, 2, 21));
    queue_request(solve_req());
    // empty store solve
    queue_request(solve_req());

    // lowered vertex count after loading: edges past it are skipped
    write_vertex_count(32);
    queue_request(add_edge(0, 31, 65535));
    queue_request(add_edge(0, 1, 3));
    queue_request(add_edge(30, 31, 65535));
    write_vertex_count(2);
    queue_request(solve_req());

    // single vertex and out-of-range register values
    write_vertex_count(1);
    queue_request(add_edge(0, 0, 9));
    queue_request(solve_req());
    write_vertex_count(0);
    queue_request(solve_req());
    write_vertex_count(63);
    // full 32 vertex spanning chain with big weights, total just under the saturation limit
    for (int v = 0; v < 31; v++) queue_request(add_edge(v, v + 1, 65535 - v));
    queue_request(solve_req());
    // store overflow: fill past capacity then solve
    write_vertex_count(8);
    for (int i = 0; i < STORE_DEPTH + 3; i++)
      queue_request(add_edge($urandom_range(7), $urandom_range(7),
                             $urandom_range(65535)));
    queue_request(solve_req());

    // pressure: once the queue is out, hold the sender until every result is back
    while (pending_requests.size() > 0) @(posedge clk);
    hold_sender = 1'b1;
    while (expected_tree.size() > 0 || in_valid) @(posedge clk);
    hold_sender = 1'b0;

    // random phases with changing idle patterns and vertex counts
    random_base = sent;
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        sender_idle_pct = 57;
        receiver_idle_pct = 32;
      end else if (phase == 2) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      while (sent < random_base + 40 * (phase + 1)) begin
        nv = ($urandom_range(3) == 0) ? $urandom_range(32, 1) : $urandom_range(8, 2);
        if (nv != live_vertices() || $urandom_range(3) == 0) write_vertex_count(nv);
        queue_graph(nv, $urandom_range(nv + 6, 1),
                    ($urandom_range(1) == 0) ? 15 : 65535);
        // occasional stretch with no idling at all
        if ($urandom_range(4) == 0) begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
